// File: src/sbpf_pkg.sv
// Shared types and constants for the servo-bus packet framer.
`default_nettype none

package sbpf_pkg;

  // Command function codes
  typedef enum logic [1:0] {
    FuncRead  = 2'd0,
    FuncWrite = 2'd1,
    FuncSync  = 2'd2,
    FuncNone  = 2'd3
  } func_t;

  localparam int SyncServosDefault = 4;
  localparam int SeenW             = 3;

  // Longest packet piece one command produces: sync header, entry and checksum
  localparam int MaxBytes = 13;
  localparam int CountW   = $clog2(MaxBytes + 1);
  localparam int QueueDepth = 2;

  localparam logic [7:0] HeaderByte     = 8'hFF;
  localparam logic [7:0] BroadcastId    = 8'hFE;
  localparam logic [7:0] InstrRead      = 8'h02;
  localparam logic [7:0] InstrWrite     = 8'h03;
  localparam logic [7:0] InstrSyncWrite = 8'h83;
  localparam logic [7:0] SyncEntryLen   = 8'h04;
  localparam logic [7:0] LenShort       = 8'h04;
  localparam logic [7:0] LenWord        = 8'h05;
  localparam logic [7:0] LenPair        = 8'h07;
  localparam logic [7:0] AddrSplit      = 8'h19;

  // One framed piece: bytes go out from index 0 upward
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CountW-1:0]        count;
    logic                     eop;
  } job_t;

endpackage

`default_nettype wire

// File: src/sbpf_if.sv
// Valid/ready channel interfaces for commands and packet bytes.
`default_nettype none

interface sbpf_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  servo_id;
  logic [7:0]  reg_address;
  logic [15:0] first_value;
  logic [15:0] second_value;

  modport source (output valid, func, servo_id, reg_address, first_value, second_value,
                  input ready);
  modport sink (input valid, func, servo_id, reg_address, first_value, second_value,
                output ready);
endinterface

interface sbpf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       last_byte;
  logic       end_of_packet;

  modport source (output valid, packet_byte, last_byte, end_of_packet, input ready);
  modport sink (input valid, packet_byte, last_byte, end_of_packet, output ready);
endinterface

`default_nettype wire

// File: src/servo_bus_packet_framer_core.sv
// Top level of the servo-bus instruction packet framer.
//
//  Channel | Dir | Payload                                              | Transfer unit
//  cmd     | in  | func, servo_id, reg_address, first_value, second_value | one command
//  pkt     | out | packet_byte, last_byte, end_of_packet                | one bus byte
//
// A command is decoded in the cycle it is taken and queued (two deep); the serializer
// then sends one byte per cycle while pkt.ready holds, 5 to 13 bytes per command, so
// throughput is set by the output byte rate. Commands keep being taken while the queue
// has room, and a following command's first byte follows the previous last byte with
// no gap. Synchronous reset clears the sync run, the queue and the output register.
// Output stalls back up through the queue into cmd.ready.
`default_nettype none

module servo_bus_packet_framer_core #(
  parameter int SYNC_SERVOS = sbpf_pkg::SyncServosDefault
) (
  input  wire logic    clk,
  input  wire logic    rst,
  sbpf_cmd_if.sink     cmd,
  sbpf_byte_if.source  pkt
);

  sbpf_pkg::job_t front_job, queue_job;
  logic           front_valid, front_ready;
  logic           queue_valid, queue_pop;

  sbpf_front #(
    .SYNC_SERVOS (SYNC_SERVOS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  sbpf_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (front_valid),
    .push_job   (front_job),
    .push_ready (front_ready),
    .pop        (queue_pop),
    .pop_job    (queue_job),
    .pop_valid  (queue_valid)
  );

  sbpf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (queue_valid),
    .job       (queue_job),
    .job_pop   (queue_pop),
    .pkt       (pkt)
  );

endmodule

`default_nettype wire

// File: src/sbpf_front.sv
// Command decoder: classifies each command and builds its byte sequence and checksum.
`default_nettype none

module sbpf_front #(
  parameter int SYNC_SERVOS = sbpf_pkg::SyncServosDefault
) (
  input  wire logic         clk,
  input  wire logic         rst,
  sbpf_cmd_if.sink          cmd,
  output sbpf_pkg::job_t    job,
  output logic              job_valid,
  input  wire logic         job_ready
);

  localparam logic [7:0] SyncLen = 8'((5 * SYNC_SERVOS + 4) % 256);

  logic [sbpf_pkg::SeenW-1:0] seen, seen_next;
  logic [7:0]                 sync_sum, sync_sum_next;

  logic [7:0]   id, addr, v1lo, v1hi, v2lo, v2hi;
  logic [7:0]   sum, hsum, esum;
  logic [sbpf_pkg::SeenW:0] cnt;
  logic         first, last_entry;
  logic         accept;

  assign id   = cmd.servo_id;
  assign addr = cmd.reg_address;
  assign v1lo = cmd.first_value[7:0];
  assign v1hi = cmd.first_value[15:8];
  assign v2lo = cmd.second_value[7:0];
  assign v2hi = cmd.second_value[15:8];

  assign cmd.ready = job_ready;
  assign accept    = cmd.valid && job_ready;
  assign job_valid = cmd.valid && (sbpf_pkg::func_t'(cmd.func) != sbpf_pkg::FuncNone);

  assign first      = (seen == '0);
  assign cnt        = {1'b0, seen} + 1'b1;
  assign last_entry = (cnt >= (sbpf_pkg::SeenW + 1)'(SYNC_SERVOS));
  assign hsum = first ? 8'(sbpf_pkg::BroadcastId + SyncLen + sbpf_pkg::InstrSyncWrite
                           + addr + sbpf_pkg::SyncEntryLen)
                      : sync_sum;
  assign esum = 8'(hsum + id + v1lo + v1hi + v2lo + v2hi);

  always_comb begin
    job           = '0;
    sum           = '0;
    seen_next     = '0;
    sync_sum_next = '0;
    unique case (sbpf_pkg::func_t'(cmd.func))
      sbpf_pkg::FuncRead: begin
        sum = 8'(id + sbpf_pkg::LenShort + sbpf_pkg::InstrRead + addr + v1lo);
        job.bytes[0] = sbpf_pkg::HeaderByte;
        job.bytes[1] = sbpf_pkg::HeaderByte;
        job.bytes[2] = id;
        job.bytes[3] = sbpf_pkg::LenShort;
        job.bytes[4] = sbpf_pkg::InstrRead;
        job.bytes[5] = addr;
        job.bytes[6] = v1lo;
        job.bytes[7] = ~sum;
        job.count    = sbpf_pkg::CountW'(8);
        job.eop      = 1'b1;
      end
      sbpf_pkg::FuncWrite: begin
        job.bytes[0] = sbpf_pkg::HeaderByte;
        job.bytes[1] = sbpf_pkg::HeaderByte;
        job.bytes[2] = id;
        job.bytes[4] = sbpf_pkg::InstrWrite;
        job.bytes[5] = addr;
        job.bytes[6] = v1lo;
        job.eop      = 1'b1;
        if (addr < sbpf_pkg::AddrSplit) begin
          sum = 8'(id + sbpf_pkg::LenShort + sbpf_pkg::InstrWrite + addr + v1lo);
          job.bytes[3] = sbpf_pkg::LenShort;
          job.bytes[7] = ~sum;
          job.count    = sbpf_pkg::CountW'(8);
        end else if (addr > sbpf_pkg::AddrSplit && cmd.second_value == '0) begin
          sum = 8'(id + sbpf_pkg::LenWord + sbpf_pkg::InstrWrite + addr + v1lo + v1hi);
          job.bytes[3] = sbpf_pkg::LenWord;
          job.bytes[7] = v1hi;
          job.bytes[8] = ~sum;
          job.count    = sbpf_pkg::CountW'(9);
        end else begin
          sum = 8'(id + sbpf_pkg::LenPair + sbpf_pkg::InstrWrite + addr + v1lo + v1hi
                   + v2lo + v2hi);
          job.bytes[3]  = sbpf_pkg::LenPair;
          job.bytes[7]  = v1hi;
          job.bytes[8]  = v2lo;
          job.bytes[9]  = v2hi;
          job.bytes[10] = ~sum;
          job.count     = sbpf_pkg::CountW'(11);
        end
      end
      sbpf_pkg::FuncSync: begin
        if (first) begin
          job.bytes[0]  = sbpf_pkg::HeaderByte;
          job.bytes[1]  = sbpf_pkg::HeaderByte;
          job.bytes[2]  = sbpf_pkg::BroadcastId;
          job.bytes[3]  = SyncLen;
          job.bytes[4]  = sbpf_pkg::InstrSyncWrite;
          job.bytes[5]  = addr;
          job.bytes[6]  = sbpf_pkg::SyncEntryLen;
          job.bytes[7]  = id;
          job.bytes[8]  = v1lo;
          job.bytes[9]  = v1hi;
          job.bytes[10] = v2lo;
          job.bytes[11] = v2hi;
          job.bytes[12] = ~esum;
          job.count     = last_entry ? sbpf_pkg::CountW'(13) : sbpf_pkg::CountW'(12);
        end else begin
          job.bytes[0] = id;
          job.bytes[1] = v1lo;
          job.bytes[2] = v1hi;
          job.bytes[3] = v2lo;
          job.bytes[4] = v2hi;
          job.bytes[5] = ~esum;
          job.count    = last_entry ? sbpf_pkg::CountW'(6) : sbpf_pkg::CountW'(5);
        end
        job.eop = last_entry;
        if (!last_entry) begin
          seen_next     = cnt[sbpf_pkg::SeenW-1:0];
          sync_sum_next = esum;
        end
      end
      default: begin
        // unused code: drops an open sync run, frames nothing
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen     <= '0;
      sync_sum <= '0;
    end else if (accept) begin
      seen     <= seen_next;
      sync_sum <= sync_sum_next;
    end
  end

endmodule

`default_nettype wire

// File: src/sbpf_fifo.sv
// Short queue between the command decoder and the byte serializer.
`default_nettype none

module sbpf_fifo (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire sbpf_pkg::job_t  push_job,
  output logic                 push_ready,
  input  wire logic            pop,
  output sbpf_pkg::job_t       pop_job,
  output logic                 pop_valid
);

  localparam int PtrW = $clog2(sbpf_pkg::QueueDepth);
  localparam int CntW = $clog2(sbpf_pkg::QueueDepth + 1);

  sbpf_pkg::job_t  mem [sbpf_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push, do_pop;

  assign push_ready = (fill != CntW'(sbpf_pkg::QueueDepth));
  assign pop_valid  = (fill != '0);
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(sbpf_pkg::QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(sbpf_pkg::QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// File: src/sbpf_back.sv
// Byte serializer: shifts queued byte sequences out one byte per cycle while pkt.ready holds.
`default_nettype none

module sbpf_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            job_valid,
  input  wire sbpf_pkg::job_t  job,
  output logic                 job_pop,
  sbpf_byte_if.source          pkt
);

  logic [sbpf_pkg::MaxBytes-1:0][7:0] cur_bytes;
  logic [sbpf_pkg::CountW-1:0]        cur_left;
  logic                               cur_eop;
  logic                               out_valid, out_last, out_eop;
  logic [7:0]                         out_byte;
  logic                               advance;

  assign advance = !out_valid || pkt.ready;
  assign job_pop = advance && (cur_left == '0) && job_valid;

  assign pkt.valid         = out_valid;
  assign pkt.packet_byte   = out_byte;
  assign pkt.last_byte     = out_last;
  assign pkt.end_of_packet = out_eop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_left  <= '0;
    end else if (advance) begin
      if (cur_left != '0) begin
        out_valid <= 1'b1;
        cur_left  <= cur_left - 1'b1;
      end else if (job_valid) begin
        out_valid <= 1'b1;
        cur_left  <= job.count - 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload path, no reset needed
  always_ff @(posedge clk) begin
    if (advance) begin
      if (cur_left != '0) begin
        out_byte  <= cur_bytes[0];
        out_last  <= (cur_left == sbpf_pkg::CountW'(1));
        out_eop   <= (cur_left == sbpf_pkg::CountW'(1)) && cur_eop;
        cur_bytes <= {8'h00, cur_bytes[sbpf_pkg::MaxBytes-1:1]};
      end else begin
        out_byte  <= job.bytes[0];
        out_last  <= (job.count == sbpf_pkg::CountW'(1));
        out_eop   <= (job.count == sbpf_pkg::CountW'(1)) && job.eop;
        cur_bytes <= {8'h00, job.bytes[sbpf_pkg::MaxBytes-1:1]};
        cur_eop   <= job.eop;
      end
    end
  end

  a_eop_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eop |-> out_last)
    else $error("checksum byte not marked as last byte");

  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    cur_left <= sbpf_pkg::CountW'(sbpf_pkg::MaxBytes - 1))
    else $error("byte count out of range");

  a_last_then_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_last && cur_left == '0 |-> 0)
    else $error("sequence ended without last byte");

endmodule

`default_nettype wire
